// ===== rtl/reb_pkg.sv =====
// Shared types and codes for the rotary encoder and button event decoder.
package reb_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned IndexWidth = 8;
   localparam int unsigned OpWidth    = 2;
   localparam int unsigned EventWidth = 3;

   localparam logic [OpWidth-1:0] OP_POLL    = 2'd0;
   localparam logic [OpWidth-1:0] OP_WAIT    = 2'd1;
   localparam logic [OpWidth-1:0] OP_INIT    = 2'd2;

   localparam logic [EventWidth-1:0] EV_NONE  = 3'd0;
   localparam logic [EventWidth-1:0] EV_CW    = 3'd1;
   localparam logic [EventWidth-1:0] EV_CCW   = 3'd2;
   localparam logic [EventWidth-1:0] EV_PRESS = 3'd3;
   localparam logic [EventWidth-1:0] EV_LONG  = 3'd4;

   localparam logic [IndexWidth-1:0] REG_STEP_DEBOUNCE  = 8'd0;
   localparam logic [IndexWidth-1:0] REG_LONG_PRESS     = 8'd1;
   localparam logic [IndexWidth-1:0] REG_PRESS_DEBOUNCE = 8'd2;

   localparam logic [CfgWidth-1:0] STEP_DEBOUNCE_RESET  = 16'd5;
   localparam logic [CfgWidth-1:0] LONG_PRESS_RESET     = 16'd800;
   localparam logic [CfgWidth-1:0] PRESS_DEBOUNCE_RESET = 16'd30;

   typedef struct packed {
      logic [CfgWidth-1:0] step_debounce_ms;
      logic [CfgWidth-1:0] long_press_ms;
      logic [CfgWidth-1:0] press_debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic                 clk_level;
      logic                 dat_level;
      logic                 button_pressed;
      logic [TimeWidth-1:0] now_ms;
   } item_type;

endpackage

// ===== rtl/reb_csr.sv =====
// Configuration register file for the encoder event decoder.
module reb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [reb_pkg::IndexWidth-1:0]    csr_index,
   input  logic [reb_pkg::CfgWidth-1:0]      csr_data,
   output reb_pkg::cfg_type                  cfg
);

   reb_pkg::cfg_type cfg_ff;
   reb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            reb_pkg::REG_STEP_DEBOUNCE:  cfg_in.step_debounce_ms  = csr_data;
            reb_pkg::REG_LONG_PRESS:     cfg_in.long_press_ms     = csr_data;
            reb_pkg::REG_PRESS_DEBOUNCE: cfg_in.press_debounce_ms = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_debounce_ms  <= reb_pkg::STEP_DEBOUNCE_RESET;
         cfg_ff.long_press_ms     <= reb_pkg::LONG_PRESS_RESET;
         cfg_ff.press_debounce_ms <= reb_pkg::PRESS_DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/reb_evt.sv =====
// Encoder and button state with the single-pass event decode.
module reb_evt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  reb_pkg::item_type                   item,
   input  reb_pkg::cfg_type                    cfg,
   output logic [reb_pkg::EventWidth-1:0]      event_res
);

   logic                            last_clk_ff,   last_clk_in;
   logic [reb_pkg::TimeWidth-1:0]   last_step_ff,  last_step_in;
   logic [reb_pkg::TimeWidth-1:0]   press_start_ff, press_start_in;
   logic                            was_pressed_ff, was_pressed_in;
   logic                            press_done_ff, press_done_in;
   logic                            suppress_ff,   suppress_in;

   logic [reb_pkg::TimeWidth-1:0]   step_age;
   logic [reb_pkg::TimeWidth-1:0]   hold_time;
   logic [reb_pkg::TimeWidth-1:0]   start_eff;
   logic                            new_press;
   logic                            done_eff;
   logic                            btn;

   assign btn       = item.button_pressed;
   assign new_press = btn && !was_pressed_ff;
   assign start_eff = new_press ? item.now_ms : press_start_ff;
   assign done_eff  = new_press ? 1'b0 : press_done_ff;
   assign step_age  = item.now_ms - last_step_ff;
   assign hold_time = item.now_ms - start_eff;

   always_comb begin
      last_clk_in    = last_clk_ff;
      last_step_in   = last_step_ff;
      press_start_in = press_start_ff;
      was_pressed_in = was_pressed_ff;
      press_done_in  = press_done_ff;
      suppress_in    = suppress_ff;
      event_res      = reb_pkg::EV_NONE;
      case (item.operation)
         reb_pkg::OP_POLL: begin
            last_clk_in = item.clk_level;
            if (suppress_ff) begin
               if (!btn) begin
                  suppress_in    = 1'b0;
                  was_pressed_in = 1'b0;
                  press_done_in  = 1'b1;
               end else begin
                  was_pressed_in = 1'b1;
               end
            end else begin
               if (item.clk_level && !last_clk_ff &&
                   step_age >= {16'd0, cfg.step_debounce_ms}) begin
                  last_step_in = item.now_ms;
                  event_res    = (item.dat_level != item.clk_level) ?
                                 reb_pkg::EV_CW : reb_pkg::EV_CCW;
               end
               press_start_in = start_eff;
               press_done_in  = done_eff;
               if (btn && !done_eff && hold_time >= {16'd0, cfg.long_press_ms}) begin
                  press_done_in = 1'b1;
                  event_res     = reb_pkg::EV_LONG;
               end
               if (!btn && was_pressed_ff && !done_eff) begin
                  if (hold_time >= {16'd0, cfg.press_debounce_ms}) begin
                     event_res = reb_pkg::EV_PRESS;
                  end
                  press_done_in = 1'b1;
               end
               was_pressed_in = btn;
            end
         end
         reb_pkg::OP_WAIT: begin
            if (btn) begin
               suppress_in = 1'b1;
            end
            was_pressed_in = btn;
            press_done_in  = 1'b1;
         end
         reb_pkg::OP_INIT: begin
            last_clk_in = item.clk_level;
         end
         default: begin
            event_res = reb_pkg::EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clk_ff    <= 1'b0;
         last_step_ff   <= '0;
         press_start_ff <= '0;
         was_pressed_ff <= 1'b0;
         press_done_ff  <= 1'b0;
         suppress_ff    <= 1'b0;
      end else if (update) begin
         last_clk_ff    <= last_clk_in;
         last_step_ff   <= last_step_in;
         press_start_ff <= press_start_in;
         was_pressed_ff <= was_pressed_in;
         press_done_ff  <= press_done_in;
         suppress_ff    <= suppress_in;
      end
   end

endmodule

// ===== rtl/rotary_encoder_button_events.sv =====
// Top level of the rotary encoder and push-button event decoder.
// An accepted req beat is held in the input register and its event in the result register.
// Throughput: one beat per cycle unless rsp_ready stalls; the decode is a single pass of
// compares and 32-bit subtractions on the state registers between the two registers.
// Reset: synchronous, active high; clears the decoder state and pipeline valids and
// loads the register defaults (step 5 ms, long press 800 ms, press 30 ms).
module rotary_encoder_button_events (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [reb_pkg::OpWidth-1:0]      req_operation,
   input  logic                             req_clk_level,
   input  logic                             req_dat_level,
   input  logic                             req_button_pressed,
   input  logic [reb_pkg::TimeWidth-1:0]    req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [reb_pkg::EventWidth-1:0]   rsp_event_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [reb_pkg::IndexWidth-1:0]   csr_index,
   input  logic [reb_pkg::CfgWidth-1:0]     csr_data
);

   reb_pkg::cfg_type                    cfg;
   reb_pkg::item_type                   item_ff;
   logic                                item_valid_ff;
   logic [reb_pkg::EventWidth-1:0]      event_in;
   logic [reb_pkg::EventWidth-1:0]      event_ff;
   logic                                rsp_valid_ff;
   logic                                advance;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = event_ff;

   reb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   reb_evt u_evt (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .event_res (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.operation      <= req_operation;
         item_ff.clk_level      <= req_clk_level;
         item_ff.dat_level      <= req_dat_level;
         item_ff.button_pressed <= req_button_pressed;
         item_ff.now_ms         <= req_now_ms;
      end
      if (advance) begin
         event_ff <= event_in;
      end
   end

endmodule

// ===== verif/rotary_encoder_button_events_tb.sv =====
// Self-checking testbench for the rotary encoder and push-button event decoder.
module rotary_encoder_button_events_tb;

   localparam logic [reb_pkg::OpWidth-1:0]    OP_UNUSED    = 2'd3;
   localparam logic [reb_pkg::IndexWidth-1:0] REG_UNMAPPED = 8'd3;
   localparam logic [reb_pkg::IndexWidth-1:0] REG_TOP      = 8'hFF;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [reb_pkg::OpWidth-1:0]    req_operation = reb_pkg::OP_POLL;
   logic                           req_clk_level = 1'b0;
   logic                           req_dat_level = 1'b0;
   logic                           req_button_pressed = 1'b0;
   logic [reb_pkg::TimeWidth-1:0]  req_now_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [reb_pkg::EventWidth-1:0] rsp_event_res;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [reb_pkg::IndexWidth-1:0] csr_index = '0;
   logic [reb_pkg::CfgWidth-1:0]   csr_data = '0;

   rotary_encoder_button_events dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_clk_level(req_clk_level),
      .req_dat_level(req_dat_level),
      .req_button_pressed(req_button_pressed),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // decoder state as the block should hold it
   reb_pkg::cfg_type              cfg = {reb_pkg::STEP_DEBOUNCE_RESET,
                                         reb_pkg::LONG_PRESS_RESET,
                                         reb_pkg::PRESS_DEBOUNCE_RESET};
   logic                          enc_clk_prev = 1'b0;
   logic [reb_pkg::TimeWidth-1:0] step_stamp = '0;
   logic [reb_pkg::TimeWidth-1:0] hold_start = '0;
   logic                          btn_was_down = 1'b0;
   logic                          hold_reported = 1'b0;
   logic                          await_release = 1'b0;

   reb_pkg::item_type              pending_items[$];
   logic [reb_pkg::EventWidth-1:0] expected_events[$];
   reb_pkg::item_type              offered_item;
   bit                             offering = 1'b0;
   int unsigned                    send_gap = 0;
   int unsigned                    rsp_stall = 0;
   bit                             no_idle = 1'b0;
   bit                             hold_rsp_long = 1'b0;
   int unsigned                    mismatch_count = 0;
   int unsigned                    gen_count = 0;
   logic [reb_pkg::TimeWidth-1:0]  gen_ms = '0;
   logic                           gen_clk = 1'b0;

   function automatic logic [reb_pkg::EventWidth-1:0] decode_event(input reb_pkg::item_type it);
      logic [reb_pkg::EventWidth-1:0] ev;
      logic [reb_pkg::TimeWidth-1:0]  held_ms;
      ev = reb_pkg::EV_NONE;
      case (it.operation)
         reb_pkg::OP_POLL: begin
            if (await_release) begin
               enc_clk_prev = it.clk_level;
               if (!it.button_pressed) begin
                  await_release = 1'b0;
                  btn_was_down = 1'b0;
                  hold_reported = 1'b1;
               end else begin
                  btn_was_down = 1'b1;
               end
            end else begin
               if (it.clk_level && !enc_clk_prev &&
                   (it.now_ms - step_stamp) >= cfg.step_debounce_ms) begin
                  step_stamp = it.now_ms;
                  ev = (it.dat_level != it.clk_level) ? reb_pkg::EV_CW : reb_pkg::EV_CCW;
               end
               enc_clk_prev = it.clk_level;
               if (it.button_pressed && !btn_was_down) begin
                  hold_start = it.now_ms;
                  hold_reported = 1'b0;
               end
               held_ms = it.now_ms - hold_start;
               if (it.button_pressed && !hold_reported && held_ms >= cfg.long_press_ms) begin
                  hold_reported = 1'b1;
                  ev = reb_pkg::EV_LONG;
               end
               if (!it.button_pressed && btn_was_down && !hold_reported) begin
                  if (held_ms >= cfg.press_debounce_ms) ev = reb_pkg::EV_PRESS;
                  hold_reported = 1'b1;
               end
               btn_was_down = it.button_pressed;
            end
         end
         reb_pkg::OP_WAIT: begin
            if (it.button_pressed) await_release = 1'b1;
            btn_was_down = it.button_pressed;
            hold_reported = 1'b1;
         end
         reb_pkg::OP_INIT: begin
            enc_clk_prev = it.clk_level;
         end
         default: ;
      endcase
      return ev;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_events.push_back(decode_event(offered_item));
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_items.size() != 0) begin
               offered_item = pending_items.pop_front();
               offering = 1'b1;
               send_gap = no_idle ? 0 : pick_gap();
               req_operation <= offered_item.operation;
               req_clk_level <= offered_item.clk_level;
               req_dat_level <= offered_item.dat_level;
               req_button_pressed <= offered_item.button_pressed;
               req_now_ms <= offered_item.now_ms;
            end
         end
         req_valid <= offering;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rsp_check
      logic [reb_pkg::EventWidth-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: event_res expected none, got %0d", $time, rsp_event_res);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_res !== want) begin
                  $display("%0t: event_res expected %0d, got %0d",
                           $time, want, rsp_event_res);
                  mismatch_count++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_stall = 299;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle) rsp_stall = pick_gap();
         end
      end
   end

   task automatic queue_item(input logic [reb_pkg::OpWidth-1:0] op, input logic c,
                             input logic d, input logic b,
                             input logic [reb_pkg::TimeWidth-1:0] t);
      reb_pkg::item_type it;
      it.operation = op;
      it.clk_level = c;
      it.dat_level = d;
      it.button_pressed = b;
      it.now_ms = t;
      pending_items.push_back(it);
      if (op != OP_UNUSED) gen_count++;
   endtask

   task automatic write_reg(input logic [reb_pkg::IndexWidth-1:0] idx,
                            input logic [reb_pkg::CfgWidth-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         reb_pkg::REG_STEP_DEBOUNCE:  cfg.step_debounce_ms = val;
         reb_pkg::REG_LONG_PRESS:     cfg.long_press_ms = val;
         reb_pkg::REG_PRESS_DEBOUNCE: cfg.press_debounce_ms = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [reb_pkg::CfgWidth-1:0] step_ms,
                             input logic [reb_pkg::CfgWidth-1:0] long_ms,
                             input logic [reb_pkg::CfgWidth-1:0] press_ms);
      write_reg(reb_pkg::REG_STEP_DEBOUNCE, step_ms);
      write_reg(reb_pkg::REG_LONG_PRESS, long_ms);
      write_reg(reb_pkg::REG_PRESS_DEBOUNCE, press_ms);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || offering || expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic gen_rotation();
      int unsigned n;
      n = $urandom_range(2, 8);
      repeat (n) begin
         gen_ms += $urandom_range(0, 2 * cfg.step_debounce_ms + 2);
         gen_clk = ~gen_clk;
         queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b0, gen_ms);
      end
   endtask

   // hold lengths straddle the press and long-press thresholds
   task automatic gen_press();
      logic [reb_pkg::TimeWidth-1:0] t0;
      logic [reb_pkg::TimeWidth-1:0] dur;
      int unsigned                   n_mid;
      t0 = gen_ms;
      case ($urandom_range(0, 5))
         0: dur = (cfg.press_debounce_ms == 0) ? 0 : cfg.press_debounce_ms - 1;
         1: dur = cfg.press_debounce_ms;
         2: dur = cfg.long_press_ms;
         3: dur = cfg.long_press_ms + $urandom_range(1, 50);
         default: dur = $urandom_range(0, cfg.long_press_ms + 10);
      endcase
      queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b1, t0);
      n_mid = $urandom_range(0, 3);
      for (int unsigned j = 1; j <= n_mid; j++) begin
         gen_clk = 1'($urandom_range(0, 1));
         queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b1,
                    t0 + dur * j / (n_mid + 1));
      end
      if ($urandom_range(0, 1)) begin
         gen_clk = 1'($urandom_range(0, 1));
         queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b1, t0 + dur);
      end
      queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b0, t0 + dur);
      gen_ms = t0 + dur + $urandom_range(0, 5);
   endtask

   task automatic gen_wait();
      logic        held;
      int unsigned n;
      held = ($urandom_range(0, 3) != 0);
      queue_item(reb_pkg::OP_WAIT, gen_clk, 1'($urandom_range(0, 1)), held, gen_ms);
      if (held) begin
         n = $urandom_range(0, 4);
         repeat (n) begin
            gen_ms += $urandom_range(0, cfg.long_press_ms + 2);
            gen_clk = 1'($urandom_range(0, 1));
            queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b1, gen_ms);
         end
         gen_ms += $urandom_range(0, 50);
         queue_item(reb_pkg::OP_POLL, gen_clk, 1'($urandom_range(0, 1)), 1'b0, gen_ms);
      end
   endtask

   task automatic run_random(input int unsigned n);
      int unsigned start;
      int unsigned pick;
      start = gen_count;
      while (gen_count - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            gen_rotation();
         end else if (pick < 63) begin
            gen_press();
         end else if (pick < 73) begin
            gen_wait();
         end else if (pick < 78) begin
            gen_clk = 1'($urandom_range(0, 1));
            queue_item(reb_pkg::OP_INIT, gen_clk, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), gen_ms);
         end else if (pick < 81) begin
            gen_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
         end else begin
            queue_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_item(reb_pkg::OP_INIT, 1'b0, 1'b0, 1'b0, 32'd0);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b0, 32'd10);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b0, 1'b0, 32'd11);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b1, 1'b0, 32'd12);   // inside step debounce
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b1, 1'b0, 32'd20);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b1, 1'b0, 32'd30);
      queue_item(OP_UNUSED,        1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd100);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b0, 32'd110);  // released too early
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd200);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b0, 32'd230);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd300);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd1100);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd1200);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b0, 1'b0, 32'd1300);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b1, 1'b1, 32'd1500);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b0, 1'b1, 32'd2300); // step and long press together
      queue_item(reb_pkg::OP_WAIT, 1'b1, 1'b0, 1'b1, 32'd2400);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b0, 1'b1, 32'd2500);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b1, 1'b1, 32'd2600);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b0, 1'b0, 32'd2700);
      queue_item(reb_pkg::OP_WAIT, 1'b0, 1'b0, 1'b0, 32'd2800);
      queue_item(reb_pkg::OP_INIT, 1'b1, 1'b0, 1'b0, 32'd2900);
      queue_item(reb_pkg::OP_POLL, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0);
      queue_item(reb_pkg::OP_POLL, 1'b1, 1'b1, 1'b1, 32'h0000_0330); // timestamp wrapped
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_config(16'd0, 16'd0, 16'd0);
            1: begin
               set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
               write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
               write_reg(REG_TOP, 16'($urandom_range(0, 65535)));
            end
            2: set_config(16'($urandom_range(1, 20)), 16'($urandom_range(50, 400)),
                          16'($urandom_range(5, 60)));
            3: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2000)),
                          16'($urandom_range(0, 65535)));
            default: set_config(reb_pkg::STEP_DEBOUNCE_RESET, reb_pkg::LONG_PRESS_RESET,
                                reb_pkg::PRESS_DEBOUNCE_RESET);
         endcase
         no_idle = (p == 0);
         hold_rsp_long = (p == 2);
         run_random(80);
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== rotary_encoder_button_events.f =====
rtl/reb_pkg.sv
rtl/reb_csr.sv
rtl/reb_evt.sv
rtl/rotary_encoder_button_events.sv
verif/rotary_encoder_button_events_tb.sv
